### rtl/tbi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbi_pkg
// Shared codes and types of the clamped 2-D table interpolator.
// ----------------------------------------------------------------------------
package tbi_pkg;

    localparam int DATA_W = 32;

    // input item kinds
    localparam logic [1:0] KIND_ROW_LOAD = 2'd0;
    localparam logic [1:0] KIND_TAB_LOAD = 2'd1;
    localparam logic [1:0] KIND_QUERY    = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;   // ignored, no result

    // configuration register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam int CFG_W = 7;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } t_div_rsp;

endpackage

### rtl/tbi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbi_if
// Valid/ready channels: query/load input beats and result beats.
// ----------------------------------------------------------------------------
interface tbi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  row;
    logic [5:0]  col;
    logic [31:0] field_value;
    logic [31:0] energy_value;
    logic [31:0] coeff_value;

    modport source (
        output valid, kind, row, col, field_value, energy_value, coeff_value,
        input  ready
    );
    modport sink (
        input  valid, kind, row, col, field_value, energy_value, coeff_value,
        output ready
    );
endinterface

interface tbi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] interpolated_value;

    modport source (output valid, interpolated_value, input ready);
    modport sink   (input valid, interpolated_value, output ready);
endinterface

### rtl/clamped_2d_table_interpolator.sv
`timescale 1ns / 1ps
// A load beat is written straight into memory when it is accepted.
// A query result is registered once the row axis and the energy tables of
// the one or two bracketing rows are scanned; a bracket that falls between
// two points also waits for the divider. Throughput: one load beat a cycle
// while idle; a query holds off the next beat until its result is registered.
// Reset: synchronous active-low; registers return to 1, tables are undefined.
// ----------------------------------------------------------------------------
// clamped_2d_table_interpolator
// Bracketed two-level linear interpolation over a row axis and per-row
// (energy, coefficient) tables held in synchronous RAM.
// ----------------------------------------------------------------------------
module clamped_2d_table_interpolator #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [tbi_pkg::CFG_W-1:0]  i_cfg_data,
    tbi_in_if.sink                     i_in,
    tbi_out_if.source                  o_out
);

    // ---- derived widths ----
    localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW   = $clog2(MAX_COLS);
    localparam int TD   = MAX_ROWS * MAX_COLS;
    localparam int AW   = $clog2(TD);
    localparam int MAXN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int IW   = $clog2(MAXN);
    localparam int NW   = $clog2(MAXN + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK0, S_CHKL, S_SCAN, S_DIV, S_DONE,
        S_MUL, S_ADD, S_AFTER, S_OUT
    } t_state;

    // which bracket the scan engine is working on
    typedef enum logic [1:0] {PH_ROW, PH_E0, PH_E1, PH_BL} t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic [4:0]    r_rows;
    logic [6:0]    r_cols;

    logic [31:0]   r_fv, n_fv;
    logic [31:0]   r_ev, n_ev;
    logic [IW-1:0] r_idx, n_idx;
    logic [31:0]   r_plo_pt, n_plo_pt;    // point at lower bracket index
    logic [31:0]   r_plo_cf, n_plo_cf;
    logic [IW-1:0] r_lo, n_lo;
    logic          r_flat, n_flat;
    logic [31:0]   r_a, n_a;              // blend operands
    logic [31:0]   r_b, n_b;
    logic [31:0]   r_w, n_w;
    logic [RW-1:0] r_rlo, n_rlo;          // row bracket result
    logic [RW-1:0] r_rhi, n_rhi;
    logic          r_rflat, n_rflat;
    logic [31:0]   r_rw, n_rw;
    logic [31:0]   r_d0, n_d0;
    logic [63:0]   r_prod, n_prod;
    logic [31:0]   r_val, n_val;
    logic          r_ovalid, n_ovalid;
    logic [31:0]   r_odata, n_odata;
    logic          r_div_start, n_div_start;
    logic [31:0]   r_div_num, n_div_num;
    logic [31:0]   r_div_den, n_div_den;

    tbi_pkg::t_div_req div_req;
    tbi_pkg::t_div_rsp div_rsp;

    // ---- memories ----
    logic          row_we;
    logic [RW-1:0] row_waddr;
    logic [RW-1:0] row_raddr;
    logic [31:0]   row_rd;
    logic          tab_we;
    logic [AW-1:0] tab_waddr;
    logic [AW-1:0] tab_raddr;
    logic [63:0]   tab_rd;
    logic [RW-1:0] rd_base;

    logic          in_acc;
    logic [NW-1:0] nr;
    logic [NW-1:0] nc;
    logic [NW-1:0] n_cur;
    logic [31:0]   x_cur;
    logic [31:0]   src_pt;
    logic [31:0]   src_cf;
    logic [31:0]   diff;
    logic [63:0]   rnd;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign row_we    = in_acc && (i_in.kind == tbi_pkg::KIND_ROW_LOAD)
                       && (32'(i_in.row) < 32'(MAX_ROWS));
    assign row_waddr = RW'(i_in.row);
    assign tab_we    = in_acc && (i_in.kind == tbi_pkg::KIND_TAB_LOAD)
                       && (32'(i_in.row) < 32'(MAX_ROWS))
                       && (32'(i_in.col) < 32'(MAX_COLS));
    assign tab_waddr = AW'(32'(i_in.row) * 32'(MAX_COLS) + 32'(i_in.col));

    // Read address follows the next index, so the read data always belongs
    // to the index register of the current cycle.
    assign row_raddr = n_idx[RW-1:0];
    assign rd_base   = (n_phase == PH_E0) ? n_rlo : n_rhi;
    assign tab_raddr = AW'(32'(rd_base) * 32'(MAX_COLS) + 32'(n_idx[CW-1:0]));

    tbi_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (i_in.field_value),
        .i_raddr (row_raddr),
        .o_rdata (row_rd)
    );

    tbi_ram #(.WIDTH(64), .DEPTH(TD)) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata ({i_in.energy_value, i_in.coeff_value}),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rd)
    );

    assign div_req.start = r_div_start;
    assign div_req.num   = r_div_num;
    assign div_req.den   = r_div_den;

    tbi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---- clamped point counts: zero acts as one, too large as the maximum ----
    always_comb begin
        if (r_rows == 5'd0) begin
            nr = NW'(1);
        end else if (32'(r_rows) > 32'(MAX_ROWS)) begin
            nr = NW'(MAX_ROWS);
        end else begin
            nr = NW'(r_rows);
        end
        if (r_cols == 7'd0) begin
            nc = NW'(1);
        end else if (32'(r_cols) > 32'(MAX_COLS)) begin
            nc = NW'(MAX_COLS);
        end else begin
            nc = NW'(r_cols);
        end
    end

    assign n_cur  = (r_phase == PH_ROW) ? nr : nc;
    assign x_cur  = (r_phase == PH_ROW) ? r_fv : r_ev;
    assign src_pt = (r_phase == PH_ROW) ? row_rd : tab_rd[63:32];
    assign src_cf = tab_rd[31:0];

    // blend: a + (b - a) * w / 2^32, rounded to nearest, halves away from a
    assign diff = (r_b >= r_a) ? (r_b - r_a) : (r_a - r_b);
    assign rnd  = r_prod + 64'h0000_0000_8000_0000;

    // ---- query sequencer ----
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_fv        = r_fv;
        n_ev        = r_ev;
        n_idx       = r_idx;
        n_plo_pt    = r_plo_pt;
        n_plo_cf    = r_plo_cf;
        n_lo        = r_lo;
        n_flat      = r_flat;
        n_a         = r_a;
        n_b         = r_b;
        n_w         = r_w;
        n_rlo       = r_rlo;
        n_rhi       = r_rhi;
        n_rflat     = r_rflat;
        n_rw        = r_rw;
        n_d0        = r_d0;
        n_prod      = r_prod;
        n_val       = r_val;
        n_ovalid    = r_ovalid && !o_out.ready;
        n_odata     = r_odata;
        n_div_start = 1'b0;
        n_div_num   = r_div_num;
        n_div_den   = r_div_den;

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.kind == tbi_pkg::KIND_QUERY)) begin
                    n_fv    = i_in.field_value;
                    n_ev    = i_in.energy_value;
                    n_phase = PH_ROW;
                    n_idx   = '0;
                    n_state = S_CHK0;
                end
            end
            S_CHK0: begin
                // clamp below the first point
                n_plo_pt = src_pt;
                n_plo_cf = src_cf;
                if ((n_cur <= NW'(1)) || (x_cur <= src_pt)) begin
                    n_lo    = '0;
                    n_flat  = 1'b1;
                    n_a     = src_cf;
                    n_w     = '0;
                    n_state = S_DONE;
                end else begin
                    n_idx   = IW'(n_cur - NW'(1));
                    n_state = S_CHKL;
                end
            end
            S_CHKL: begin
                // clamp above the last point
                if (x_cur >= src_pt) begin
                    n_lo    = r_idx;
                    n_flat  = 1'b1;
                    n_a     = src_cf;
                    n_w     = '0;
                    n_state = S_DONE;
                end else begin
                    n_idx   = IW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if ((x_cur < src_pt) || ((32'(r_idx) + 32'd1) >= 32'(n_cur))) begin
                    n_lo   = r_idx - IW'(1);
                    n_flat = 1'b0;
                    n_a    = r_plo_cf;
                    n_b    = src_cf;
                    n_w    = '0;
                    if ((x_cur > r_plo_pt) && (src_pt > r_plo_pt)) begin
                        n_div_start = 1'b1;
                        n_div_num   = x_cur - r_plo_pt;
                        n_div_den   = src_pt - r_plo_pt;
                        n_state     = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_plo_pt = src_pt;
                    n_plo_cf = src_cf;
                    n_idx    = r_idx + IW'(1);
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_w     = div_rsp.quot;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (r_phase == PH_ROW) begin
                    n_rlo   = r_lo[RW-1:0];
                    n_rhi   = r_flat ? r_lo[RW-1:0] : RW'(r_lo + IW'(1));
                    n_rflat = r_flat;
                    n_rw    = r_w;
                    n_phase = PH_E0;
                    n_idx   = '0;
                    n_state = S_CHK0;
                end else if (r_flat) begin
                    n_val   = r_a;
                    n_state = S_AFTER;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = 64'(diff) * 64'(r_w);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_val   = (r_b >= r_a) ? (r_a + rnd[63:32]) : (r_a - rnd[63:32]);
                n_state = S_AFTER;
            end
            S_AFTER: begin
                case (r_phase)
                    PH_E0: begin
                        n_d0 = r_val;
                        if (r_rflat) begin
                            n_state = S_OUT;
                        end else begin
                            n_phase = PH_E1;
                            n_idx   = '0;
                            n_state = S_CHK0;
                        end
                    end
                    PH_E1: begin
                        n_a     = r_d0;
                        n_b     = r_val;
                        n_w     = r_rw;
                        n_phase = PH_BL;
                        n_state = S_MUL;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                // result is loaded once the output register is empty or being taken
                if (!r_ovalid || o_out.ready) begin
                    n_odata  = r_val;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_fv        <= n_fv;
        r_ev        <= n_ev;
        r_idx       <= n_idx;
        r_plo_pt    <= n_plo_pt;
        r_plo_cf    <= n_plo_cf;
        r_lo        <= n_lo;
        r_flat      <= n_flat;
        r_a         <= n_a;
        r_b         <= n_b;
        r_w         <= n_w;
        r_rlo       <= n_rlo;
        r_rhi       <= n_rhi;
        r_rflat     <= n_rflat;
        r_rw        <= n_rw;
        r_d0        <= n_d0;
        r_prod      <= n_prod;
        r_val       <= n_val;
        r_odata     <= n_odata;
        r_div_num   <= n_div_num;
        r_div_den   <= n_div_den;
        r_state     <= n_state;
        r_phase     <= n_phase;
        r_ovalid    <= n_ovalid;
        r_div_start <= n_div_start;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                tbi_pkg::REG_ROWS: r_rows <= i_cfg_data[4:0];
                tbi_pkg::REG_COLS: r_cols <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_ROW;
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
            r_rows      <= 5'd1;
            r_cols      <= 7'd1;
        end
    end

    assign o_out.valid              = r_ovalid;
    assign o_out.interpolated_value = r_odata;

endmodule

### rtl/tbi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/tbi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbi_div
// Restoring divider, one quotient bit per cycle: quot = (num << 32) / den.
// Expects num < den, so the quotient fits in 32 bits.
// ----------------------------------------------------------------------------
module tbi_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tbi_pkg::t_div_req i_req,
    output tbi_pkg::t_div_rsp o_rsp
);

    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [31:0] r_quot;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] shifted;
    logic        ge;
    logic [32:0] diff;

    assign shifted = {r_rem, 1'b0};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            r_cnt  <= 5'd31;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[31:0] : shifted[31:0];
            r_quot <= {r_quot[30:0], ge};
            r_cnt  <= r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

### tb/sv/clamped_2d_table_interpolator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_2d_table_interpolator_checker
// Watches the config port and both channels, keeps a shadow copy of the
// tables, predicts each query result and compares it in order.
// ----------------------------------------------------------------------------
module clamped_2d_table_interpolator_checker #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [tbi_pkg::CFG_W-1:0] i_cfg_data,
    tbi_in_if                         i_in,
    tbi_out_if                        i_out,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_results
);

    bit [31:0] axis_shadow [MAX_COLS];
    bit [31:0] energy_shadow [MAX_ROWS][MAX_COLS];
    bit [31:0] coeff_shadow [MAX_ROWS][MAX_COLS];
    bit [4:0]  rows_reg;
    bit [6:0]  cols_reg;
    bit [31:0] interp_q [$];

    function automatic int eff_count(int v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic void find_bracket(input bit [31:0] p [MAX_COLS], input int n,
                                         input bit [31:0] x, output int lo,
                                         output int hi, output bit [63:0] w);
        int        i;
        bit [63:0] num;
        bit [63:0] den;
        i = 0;
        w = '0;
        lo = 0;
        hi = 0;
        if (n <= 1 || x <= p[0]) return;
        if (x >= p[n-1]) begin
            lo = n - 1;
            hi = n - 1;
            return;
        end
        while (i + 2 < n && x >= p[i+1]) i++;
        lo = i;
        hi = i + 1;
        if (x > p[i] && p[i+1] > p[i]) begin
            num = 64'(x - p[i]) << 32;
            den = 64'(p[i+1] - p[i]);
            w = num / den;
        end
    endfunction

    // product term rounds half away from a
    function automatic bit [31:0] mix(bit [31:0] a, bit [31:0] b, bit [63:0] w);
        bit [63:0] t;
        if (b >= a) begin
            t = (64'(b - a) * w + 64'h8000_0000) >> 32;
            return a + t[31:0];
        end
        t = (64'(a - b) * w + 64'h8000_0000) >> 32;
        return a - t[31:0];
    endfunction

    function automatic bit [31:0] row_coeff(int r, int nc, bit [31:0] e);
        bit [31:0] ep [MAX_COLS];
        int        lo;
        int        hi;
        bit [63:0] w;
        ep = energy_shadow[r];
        find_bracket(ep, nc, e, lo, hi, w);
        if (lo == hi) return coeff_shadow[r][lo];
        return mix(coeff_shadow[r][lo], coeff_shadow[r][hi], w);
    endfunction

    function automatic bit [31:0] predict_interp(bit [31:0] fv, bit [31:0] ev);
        int        nr;
        int        nc;
        int        lo;
        int        hi;
        bit [63:0] w;
        bit [31:0] d0;
        nr = eff_count(int'(rows_reg), MAX_ROWS);
        nc = eff_count(int'(cols_reg), MAX_COLS);
        find_bracket(axis_shadow, nr, fv, lo, hi, w);
        d0 = row_coeff(lo, nc, ev);
        if (lo == hi) return d0;
        return mix(d0, row_coeff(hi, nc, ev), w);
    endfunction

    assign o_pending = interp_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg <= 5'd1;
            cols_reg <= 7'd1;
            o_fail_count <= 0;
            o_results <= 0;
            interp_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == tbi_pkg::REG_ROWS) rows_reg <= i_cfg_data[4:0];
                else cols_reg <= i_cfg_data;
            end
            if (i_in.valid && i_in.ready) begin
                case (i_in.kind)
                    tbi_pkg::KIND_ROW_LOAD: axis_shadow[i_in.row] = i_in.field_value;
                    tbi_pkg::KIND_TAB_LOAD: begin
                        energy_shadow[i_in.row][i_in.col] = i_in.energy_value;
                        coeff_shadow[i_in.row][i_in.col] = i_in.coeff_value;
                    end
                    tbi_pkg::KIND_QUERY:
                        interp_q.push_back(predict_interp(i_in.field_value,
                                                          i_in.energy_value));
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                o_results <= o_results + 1;
                if (interp_q.size() == 0) begin
                    $error("unexpected result beat, interpolated_value %h",
                           i_out.interpolated_value);
                    o_fail_count <= o_fail_count + 1;
                end else if (interp_q[0] !== i_out.interpolated_value) begin
                    $error("interpolated_value mismatch: expected %h, actual %h",
                           interp_q[0], i_out.interpolated_value);
                    o_fail_count <= o_fail_count + 1;
                    void'(interp_q.pop_front());
                end else begin
                    void'(interp_q.pop_front());
                end
            end
        end
    end

endmodule

### tb/sv/clamped_2d_table_interpolator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_2d_table_interpolator_test
// Loads row axes and energy tables under a series of register settings,
// fires directed and random queries, and lets the checker judge results.
// ----------------------------------------------------------------------------
module clamped_2d_table_interpolator_test;

    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 64;
    localparam int N_ITEMS  = 1050;
    localparam int LIMIT    = 4_000_000;   // cycles

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic                      i_cfg_idx;
    logic [tbi_pkg::CFG_W-1:0] i_cfg_data;

    tbi_in_if  in_ch ();
    tbi_out_if out_ch ();

    int fail_count;
    int pending;
    int results;

    clamped_2d_table_interpolator #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    clamped_2d_table_interpolator_checker #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    // Stimulus-side view of what was loaded, so queries can aim at points
    // and never touch an entry that was never written.
    bit [31:0] axis_val [MAX_ROWS];
    bit [31:0] energy_val [MAX_ROWS][MAX_COLS];
    bit        axis_ok [MAX_ROWS];
    bit        table_ok [MAX_ROWS][MAX_COLS];

    int n_beats;        // accepted beats of kinds 0..2
    int n_queries;
    int n_settings;
    int send_idle;      // percent of cycles the sender holds off
    int recv_idle;      // percent of cycles the receiver stalls
    int cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random back-pressure at the current stall rate.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Idle mix follows progress: receiver-heavy stalls, then sender-heavy gaps,
    // then full rate on both sides.
    always @(posedge i_clk) begin
        if (n_beats < N_ITEMS / 3) begin
            send_idle <= 26;
            recv_idle <= 84;
        end else if (n_beats < 2 * N_ITEMS / 3) begin
            send_idle <= 84;
            recv_idle <= 26;
        end else begin
            send_idle <= 0;
            recv_idle <= 0;
        end
    end

    // One input beat. Gap cycles first, then hold valid until accepted.
    // valid stays high on return so back-to-back beats see one assignment
    // per edge.
    task automatic send_beat(logic [1:0] kind, logic [3:0] row, logic [5:0] col,
                             logic [31:0] fv, logic [31:0] ev, logic [31:0] cv);
        while ($urandom_range(0, 99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.row          <= row;
        in_ch.col          <= col;
        in_ch.field_value  <= fv;
        in_ch.energy_value <= ev;
        in_ch.coeff_value  <= cv;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (kind != tbi_pkg::KIND_UNUSED) n_beats++;
        if (kind == tbi_pkg::KIND_QUERY) n_queries++;
    endtask

    // Drain: wait for every expected result, then a short tail so a load
    // or ignored beat still in flight has settled.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [tbi_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [tbi_pkg::CFG_W-1:0] rows,
                            logic [tbi_pkg::CFG_W-1:0] cols);
        drain();
        write_reg(tbi_pkg::REG_ROWS, rows);
        write_reg(tbi_pkg::REG_COLS, cols);
        n_settings++;
    endtask

    // Ascending run of n values; mostly spread, sometimes tightly packed,
    // sometimes up against the top of the range.
    task automatic make_ascending(int n, output bit [31:0] v [MAX_COLS]);
        bit [31:0] cur;
        bit [31:0] span;
        case ($urandom_range(0, 3))
            0: begin cur = 32'h0;           span = 32'h0800_0000 / MAX_COLS * 16; end
            1: begin cur = 32'hF000_0000;   span = 32'h0020_0000; end
            2: begin cur = $urandom_range(0, 32'h1000_0000); span = 3; end
            default: begin
                cur = $urandom_range(0, 32'h1000_0000);
                span = 32'h0200_0000;
            end
        endcase
        for (int i = 0; i < MAX_COLS; i++) begin
            v[i] = cur;
            if (i < n) cur = cur + $urandom_range(1, span);
        end
    endtask

    // Load the row axis and the tables for the first nr x nc entries.
    // Entries already written are reloaded only when fresh is set.
    task automatic load_tables(int nr, int nc, bit fresh);
        bit [31:0] v [MAX_COLS];
        bit        scramble;
        scramble = ($urandom_range(0, 9) == 0);   // unsorted axis now and then
        make_ascending(nr, v);
        for (int r = 0; r < nr; r++) begin
            if (fresh || !axis_ok[r]) begin
                axis_val[r] = scramble ? $urandom : v[r];
                axis_ok[r] = 1'b1;
                send_beat(tbi_pkg::KIND_ROW_LOAD, 4'(r), 6'($urandom), axis_val[r],
                          $urandom, $urandom);
            end
        end
        for (int r = 0; r < nr; r++) begin
            make_ascending(nc, v);
            for (int c = 0; c < nc; c++) begin
                if (fresh || !table_ok[r][c]) begin
                    energy_val[r][c] = v[c];
                    table_ok[r][c] = 1'b1;
                    send_beat(tbi_pkg::KIND_TAB_LOAD, 4'(r), 6'(c), $urandom, v[c],
                              $urandom);
                end
            end
        end
    endtask

    // Pick a value near the points p[0..n-1]: on, just off, between, or
    // outside them, with some fully random picks.
    function automatic bit [31:0] aim_at(bit [31:0] p [MAX_COLS], int n);
        int i;
        i = $urandom_range(0, n - 1);
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return p[i];
            2: return p[i] + 1;
            3: return p[i] - 1;
            4: return (i + 1 < n) ? p[i] + (p[i+1] - p[i]) / 2 : p[i];
            5: return 32'h0;
            6: return 32'hFFFF_FFFF;
            default: return (i + 1 < n) ? p[i] + $urandom_range(0, p[i+1] - p[i]) : p[i];
        endcase
    endfunction

    task automatic random_query(int nr, int nc);
        bit [31:0] pa [MAX_COLS];
        bit [31:0] fv;
        bit [31:0] ev;
        foreach (pa[i]) pa[i] = (i < MAX_ROWS) ? axis_val[i] : 32'h0;
        fv = aim_at(pa, nr);
        ev = aim_at(energy_val[$urandom_range(0, nr - 1)], nc);
        send_beat(tbi_pkg::KIND_QUERY, 4'($urandom), 6'($urandom), fv, ev, $urandom);
    endtask

    function automatic int eff(int v, int maxv);
        return (v == 0) ? 1 : (v > maxv) ? maxv : v;
    endfunction

    initial begin
        logic [4:0] rows_set;
        logic [6:0] cols_set;
        int         nr;
        int         nc;
        int         nq;

        n_beats = 0;
        n_queries = 0;
        n_settings = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= tbi_pkg::REG_ROWS;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.kind <= tbi_pkg::KIND_ROW_LOAD;
        in_ch.row <= '0;
        in_ch.col <= '0;
        in_ch.field_value <= '0;
        in_ch.energy_value <= '0;
        in_ch.coeff_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers (one row, one column), extremes of fields.
        send_beat(tbi_pkg::KIND_ROW_LOAD, 4'd0, 6'd63, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_beat(tbi_pkg::KIND_TAB_LOAD, 4'd0, 6'd0, 32'hFFFF_FFFF, 32'h0001_2340,
                  32'hFFFF_FFFF);
        axis_val[0] = 32'h8000_0000;
        energy_val[0][0] = 32'h0001_2340;
        axis_ok[0] = 1'b1;
        table_ok[0][0] = 1'b1;
        send_beat(tbi_pkg::KIND_QUERY, 4'hF, 6'h3F, 32'h0, 32'h0, 32'h0);
        send_beat(tbi_pkg::KIND_QUERY, 4'h0, 6'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        // unused kind: ignored, no result
        send_beat(tbi_pkg::KIND_UNUSED, 4'hF, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        // zero registers act as one
        set_regs(7'd0, 7'd0);
        send_beat(tbi_pkg::KIND_QUERY, 4'h5, 6'h2A, 32'h8000_0000, 32'h0001_2340, 32'h0);
        // two by two: interpolation between points, rising and falling coeffs
        set_regs(7'd2, 7'd2);
        send_beat(tbi_pkg::KIND_ROW_LOAD, 4'd0, 6'd0, 32'h0000_0100, 32'h0, 32'h0);
        send_beat(tbi_pkg::KIND_ROW_LOAD, 4'd1, 6'd0, 32'hFFFF_FF00, 32'h0, 32'h0);
        send_beat(tbi_pkg::KIND_TAB_LOAD, 4'd0, 6'd1, 32'h0, 32'h0010_0000, 32'h0);
        send_beat(tbi_pkg::KIND_TAB_LOAD, 4'd1, 6'd0, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send_beat(tbi_pkg::KIND_TAB_LOAD, 4'd1, 6'd1, 32'h0, 32'hFFFF_FFFF, 32'h1);
        axis_val[0] = 32'h100;
        axis_val[1] = 32'hFFFF_FF00;
        energy_val[0][1] = 32'h0010_0000;
        energy_val[1][0] = 32'h0;
        energy_val[1][1] = 32'hFFFF_FFFF;
        axis_ok[1] = 1'b1;
        table_ok[0][1] = 1'b1;
        table_ok[1][0] = 1'b1;
        table_ok[1][1] = 1'b1;
        send_beat(tbi_pkg::KIND_QUERY, 4'd0, 6'd0, 32'h8000_0000, 32'h0008_0000, 32'h0);
        send_beat(tbi_pkg::KIND_QUERY, 4'd0, 6'd0, 32'h0000_0101, 32'h7FFF_FFFF, 32'h0);
        send_beat(tbi_pkg::KIND_QUERY, 4'd0, 6'd0, 32'hFFFF_FEFF, 32'h0001_2340, 32'h0);
        send_beat(tbi_pkg::KIND_QUERY, 4'd0, 6'd0, 32'hFFFF_FF00, 32'h0010_0000, 32'h0);
        send_beat(tbi_pkg::KIND_QUERY, 4'd0, 6'd0, 32'h0000_0100, 32'hFFFF_FFFE, 32'h0);
        // an oversized row register acts as the maximum
        set_regs(7'd31, 7'd1);
        load_tables(MAX_ROWS, 1, 1'b0);
        random_query(MAX_ROWS, 1);
        random_query(MAX_ROWS, 1);

        // Random phases: each picks a setting, loads what it needs, queries.
        while (n_beats < N_ITEMS) begin
            case ($urandom_range(0, 4))
                0: rows_set = 5'd0;
                1: rows_set = 5'd16;
                2: rows_set = 5'($urandom_range(17, 31));
                default: rows_set = 5'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 5))
                0: cols_set = 7'd0;
                1: cols_set = 7'd64;
                2: cols_set = 7'($urandom_range(65, 127));
                3: cols_set = 7'd2;
                default: cols_set = 7'($urandom_range(1, 64));
            endcase
            nr = eff(int'(rows_set), MAX_ROWS);
            nc = eff(int'(cols_set), MAX_COLS);
            // keep each load pass short; large in one dimension, small in the other
            if (nr * nc > 128) begin
                if ($urandom_range(0, 1)) rows_set = 5'(128 / nc);
                else cols_set = 7'(128 / nr);
                nr = eff(int'(rows_set), MAX_ROWS);
                nc = eff(int'(cols_set), MAX_COLS);
            end
            set_regs({2'b00, rows_set}, cols_set);
            load_tables(nr, nc, $urandom_range(0, 2) == 0);
            nq = $urandom_range(20, 60);
            for (int q = 0; q < nq; q++) begin
                case ($urandom_range(0, 19))
                    0: send_beat(tbi_pkg::KIND_UNUSED, 4'($urandom), 6'($urandom),
                                 $urandom, $urandom, $urandom);
                    1: send_beat(tbi_pkg::KIND_TAB_LOAD, 4'($urandom_range(0, nr - 1)),
                                 6'($urandom_range(0, nc - 1)), $urandom,
                                 energy_val[0][0], $urandom);
                    default: random_query(nr, nc);
                endcase
                // the table-load case above may unsort a row; the model allows it
                if (q == nq / 2 && $urandom_range(0, 3) == 0) drain();
            end
        end

        drain();
        repeat (400) @(posedge i_clk);
        $display("covered %0d beats, %0d queries checked against %0d results,",
                 n_beats, n_queries, results);
        $display("over %0d register settings with three back-pressure mixes", n_settings);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/tbi_pkg.sv
rtl/tbi_if.sv
rtl/tbi_ram.sv
rtl/tbi_div.sv
rtl/clamped_2d_table_interpolator.sv
tb/sv/clamped_2d_table_interpolator_checker.sv
tb/sv/clamped_2d_table_interpolator_test.sv
